// ----- design/lpfd_pkg.sv -----
`timescale 1ns / 1ps

package lpfd_pkg;

    // Header layout, byte offsets into the message
    localparam int unsigned HEADER_BYTES = 14;
    localparam int unsigned CountWidth   = 4;
    localparam logic [CountWidth-1:0] OFS_SENDER   = 4'd0;
    localparam logic [CountWidth-1:0] OFS_RECEIVER = 4'd1;
    localparam logic [CountWidth-1:0] OFS_MSG_ID   = 4'd2;
    localparam logic [CountWidth-1:0] OFS_LENGTH   = 4'd6;
    localparam logic [CountWidth-1:0] OFS_LAST     = CountWidth'(HEADER_BYTES - 1);

    // Result kinds
    localparam logic KIND_HEADER = 1'b0;
    localparam logic KIND_BODY   = 1'b1;

    typedef struct packed {
        logic               kind;
        logic [7:0]         sender_id;
        logic [7:0]         receiver_id;
        logic signed [31:0] message_id;
        logic [63:0]        body_length;
        logic [7:0]         body_byte;
        logic               last;
    } result_t;

endpackage

// ----- design/lpfd_in_stage.sv -----
`timescale 1ns / 1ps

// Input register: holds one stream byte until the parser consumes it.
module lpfd_in_stage
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,
    input  logic       step,
    output logic       in_valid,
    output logic [7:0] in_byte
);

    logic       valid_reg;
    logic       valid_next;
    logic [7:0] byte_reg;
    logic       load;

    assign s_tready = !valid_reg || step;
    assign load     = s_tvalid && s_tready;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (step)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            byte_reg <= s_tdata;
        end
    end

    assign in_valid = valid_reg;
    assign in_byte  = byte_reg;

endmodule

// ----- design/lpfd_parser.sv -----
`timescale 1ns / 1ps

// Header collection and body countdown. One byte per step.
module lpfd_parser
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    input  logic [7:0]             in_byte,
    input  logic                   out_free,
    output logic                   step,
    output logic                   res_valid,
    output lpfd_pkg::result_t      res
);

    logic                                in_body_reg;
    logic                                in_body_next;
    logic [lpfd_pkg::CountWidth-1:0]     count_reg;
    logic [lpfd_pkg::CountWidth-1:0]     count_next;
    logic [7:0]                          sender_reg;
    logic [7:0]                          sender_next;
    logic [7:0]                          receiver_reg;
    logic [7:0]                          receiver_next;
    logic [31:0]                         msg_id_reg;
    logic [31:0]                         msg_id_next;
    logic [63:0]                         length_reg;
    logic [63:0]                         length_next;
    logic [63:0]                         remaining_reg;
    logic [63:0]                         remaining_next;

    always_comb
    begin
        logic [lpfd_pkg::CountWidth-1:0] id_ofs;
        logic [lpfd_pkg::CountWidth-1:0] len_ofs;
        logic                            fin;

        id_ofs         = count_reg - lpfd_pkg::OFS_MSG_ID;
        len_ofs        = count_reg - lpfd_pkg::OFS_LENGTH;
        fin            = (remaining_reg[63:1] == 63'd0);

        in_body_next   = in_body_reg;
        count_next     = count_reg;
        sender_next    = sender_reg;
        receiver_next  = receiver_reg;
        msg_id_next    = msg_id_reg;
        length_next    = length_reg;
        remaining_next = remaining_reg;
        res_valid      = 1'b0;
        res.kind       = lpfd_pkg::KIND_HEADER;
        res.body_byte  = 8'd0;
        res.last       = 1'b0;

        if (in_body_reg)
        begin
            res_valid     = 1'b1;
            res.kind      = lpfd_pkg::KIND_BODY;
            res.body_byte = in_byte;
            res.last      = fin;
            if (remaining_reg != 64'd0)
            begin
                remaining_next = remaining_reg - 64'd1;
            end
            if (fin)
            begin
                in_body_next = 1'b0;
                count_next   = lpfd_pkg::OFS_SENDER;
            end
        end
        else
        begin
            if (count_reg == lpfd_pkg::OFS_SENDER)
            begin
                sender_next = in_byte;
            end
            else if (count_reg == lpfd_pkg::OFS_RECEIVER)
            begin
                receiver_next = in_byte;
            end
            else if (count_reg < lpfd_pkg::OFS_LENGTH)
            begin
                msg_id_next[{id_ofs[1:0], 3'b000} +: 8] = in_byte;
            end
            else
            begin
                length_next[{len_ofs[2:0], 3'b000} +: 8] = in_byte;
            end

            if (count_reg == lpfd_pkg::OFS_LAST)
            begin
                // header complete: a zero-length body closes the message here
                count_next = lpfd_pkg::OFS_SENDER;
                res_valid  = 1'b1;
                if (length_next == 64'd0)
                begin
                    res.last = 1'b1;
                end
                else
                begin
                    remaining_next = length_next;
                    in_body_next   = 1'b1;
                end
            end
            else
            begin
                count_next = count_reg + 1'b1;
            end
        end

        res.sender_id   = sender_next;
        res.receiver_id = receiver_next;
        res.message_id  = $signed(msg_id_next);
        res.body_length = length_next;
    end

    assign step = in_valid && (!res_valid || out_free);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_body_reg   <= 1'b0;
            count_reg     <= lpfd_pkg::OFS_SENDER;
            sender_reg    <= 8'd0;
            receiver_reg  <= 8'd0;
            msg_id_reg    <= 32'd0;
            length_reg    <= 64'd0;
            remaining_reg <= 64'd0;
        end
        else if (step)
        begin
            in_body_reg   <= in_body_next;
            count_reg     <= count_next;
            sender_reg    <= sender_next;
            receiver_reg  <= receiver_next;
            msg_id_reg    <= msg_id_next;
            length_reg    <= length_next;
            remaining_reg <= remaining_next;
        end
    end

endmodule

// ----- design/lpfd_out_stage.sv -----
`timescale 1ns / 1ps

// Result register on the master side.
module lpfd_out_stage
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               load,
    input  lpfd_pkg::result_t  res,
    output logic               out_free,
    output logic               m_tvalid,
    input  logic               m_tready,
    output lpfd_pkg::result_t  held
);

    logic              valid_reg;
    logic              valid_next;
    lpfd_pkg::result_t res_reg;

    assign out_free = !valid_reg || m_tready;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_reg <= res;
        end
    end

    assign m_tvalid = valid_reg;
    assign held     = res_reg;

endmodule

// ----- design/length_prefixed_frame_deframer_top.sv -----
`timescale 1ns / 1ps

// Channel   Dir  tdata (low bit first)                               tuser  tlast
// s_*       in   in_byte[7:0]                                        -      -
// m_*       out  sender_id[7:0], receiver_id[7:0], message_id[31:0], kind   last
//                body_length[63:0], body_byte[7:0] (120 bits)
//
// One byte per cycle sustained while m_tready holds high: input register -> parser -> result register.
// An accepted byte is held in the input register, and its result in the result register.
// rst_n clears the parser back to header collection and empties both registers.
// A stall on m_tready holds the result register; the parser keeps consuming
// header bytes that make no result, and s_tready drops only once both
// registers are full.
module length_prefixed_frame_deframer_top
(
    input  logic         clk,
    input  logic         rst_n,
    // slave side: one stream byte per beat
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [7:0]   s_tdata,     // in_byte[7:0]
    // master side: one result per beat
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [119:0] m_tdata,     // sender_id, receiver_id, message_id,
                                      // body_length, body_byte
    output logic         m_tuser,     // kind: 0 header, 1 body byte
    output logic         m_tlast      // end of message
);

    logic              in_valid;
    logic [7:0]        in_byte;
    logic              step;
    logic              res_valid;
    logic              out_free;
    lpfd_pkg::result_t res;
    lpfd_pkg::result_t held;

    lpfd_in_stage u_in_stage
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .step     (step),
        .in_valid (in_valid),
        .in_byte  (in_byte)
    );

    lpfd_parser u_parser
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_byte   (in_byte),
        .out_free  (out_free),
        .step      (step),
        .res_valid (res_valid),
        .res       (res)
    );

    // a result is written only on a step that produces one
    lpfd_out_stage u_out_stage
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (step && res_valid),
        .res      (res),
        .out_free (out_free),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .held     (held)
    );

    assign m_tdata = {held.body_byte, held.body_length, held.message_id,
                      held.receiver_id, held.sender_id};
    assign m_tuser = held.kind;
    assign m_tlast = held.last;

endmodule

// ----- bench/length_prefixed_frame_deframer_top_tb.sv -----
`timescale 1ns / 1ps

module length_prefixed_frame_deframer_top_tb;

    // Run limit in clock cycles; the slowest correct run (every beat waiting
    // the longest drawn wait on both sides) stays well below this limit.
    localparam int CycleLimit = 400000;
    // Result register sits behind the input register and the parser
    localparam int DrainCycles = 20;
    localparam int RandomBytes = 800;

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [7:0]   s_tdata = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [119:0] m_tdata;      // sender_id, receiver_id, message_id, body_length, body_byte
    logic         m_tuser;      // kind
    logic         m_tlast;      // last

    length_prefixed_frame_deframer_top dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    initial
    begin
        forever #6 clk = ~clk;
    end

    // Stream bytes still to be offered, and results the parser model owes
    logic [7:0]          stream_bytes[$];
    lpfd_pkg::result_t   due_results[$];

    int fault_count  = 0;
    int fed_count    = 0;
    int results_seen = 0;
    int gap_left     = 0;
    int stall_left   = 0;
    int stall_draw   = 0;
    int cycle_count  = 0;

    // Parser model state: header collection, held header fields, body countdown
    logic        hdr_in_body;
    logic [3:0]  hdr_count;
    logic [7:0]  hdr_sender;
    logic [7:0]  hdr_receiver;
    logic [31:0] hdr_msg_id;
    logic [63:0] hdr_length;
    logic [63:0] body_left;

    initial
    begin
        hdr_in_body  = 1'b0;
        hdr_count    = '0;
        hdr_sender   = '0;
        hdr_receiver = '0;
        hdr_msg_id   = '0;
        hdr_length   = '0;
        body_left    = '0;
    end

    // Append to the tail of the stream and expectation queues
    task automatic add_stream_byte(input logic [7:0] b);
        stream_bytes = {stream_bytes, b};
    endtask

    task automatic add_due_result(input lpfd_pkg::result_t r);
        due_results = {due_results, r};
    endtask

    // Wait before a beat: zero throughout a calm stretch, else a uniform random draw
    function automatic int draw_wait(input bit calm);
        return calm ? 0 : int'($urandom_range(0, 13));
    endfunction

    // Advance the parser model by one stream byte; queue the result it gives
    task automatic deframe_byte(input logic [7:0] b);
        lpfd_pkg::result_t r;
        logic              fin;
        int                sh;
        r = '0;
        r.sender_id   = hdr_sender;
        r.receiver_id = hdr_receiver;
        r.message_id  = hdr_msg_id;
        r.body_length = hdr_length;
        if (hdr_in_body)
        begin
            // Body byte: repeats the held header, last when the countdown ends.
            // A countdown of zero cannot occur here but would also end the body.
            fin = (body_left <= 64'd1);
            r.kind      = lpfd_pkg::KIND_BODY;
            r.body_byte = b;
            r.last      = fin;
            add_due_result(r);
            if (body_left != '0)
                body_left = body_left - 64'd1;
            if (fin)
            begin
                hdr_in_body = 1'b0;
                hdr_count   = '0;
            end
        end
        else
        begin
            if (hdr_count == lpfd_pkg::OFS_SENDER)
                hdr_sender = b;
            else if (hdr_count == lpfd_pkg::OFS_RECEIVER)
                hdr_receiver = b;
            else if (hdr_count < lpfd_pkg::OFS_LENGTH)
            begin
                sh = 8 * (int'(hdr_count) - int'(lpfd_pkg::OFS_MSG_ID));
                hdr_msg_id[sh +: 8] = b;
            end
            else
            begin
                sh = 8 * (int'(hdr_count) - int'(lpfd_pkg::OFS_LENGTH));
                hdr_length[sh +: 8] = b;
            end

            if (hdr_count != lpfd_pkg::OFS_LAST)
                hdr_count = hdr_count + 4'd1;
            else
            begin
                // Header complete: result carries the new fields, body_byte 0,
                // and ends the message at once when the body is empty
                hdr_count     = '0;
                r.kind        = lpfd_pkg::KIND_HEADER;
                r.sender_id   = hdr_sender;
                r.receiver_id = hdr_receiver;
                r.message_id  = hdr_msg_id;
                r.body_length = hdr_length;
                r.body_byte   = '0;
                r.last        = (hdr_length == '0);
                add_due_result(r);
                body_left   = hdr_length;
                hdr_in_body = (hdr_length != '0);
            end
        end
    endtask

    // Header bytes little-endian, then n_body random body bytes
    task automatic queue_message(input logic [7:0] snd, input logic [7:0] rcv,
                                 input logic [31:0] id, input logic [63:0] len,
                                 input int n_body);
        add_stream_byte(snd);
        add_stream_byte(rcv);
        for (int i = 0; i < 4; i++)
            add_stream_byte(id[8*i +: 8]);
        for (int i = 0; i < 8; i++)
            add_stream_byte(len[8*i +: 8]);
        for (int i = 0; i < n_body; i++)
            add_stream_byte(8'($urandom_range(0, 255)));
    endtask

    task automatic report(input string field, input logic [63:0] want, input logic [63:0] got);
        if (want !== got)
        begin
            $display("%0t ns: %s mismatch, expected %0h, got %0h", $time, field, want, got);
            fault_count++;
        end
    endtask

    // Compare the result beat on the master side with the oldest expectation
    task automatic check_result();
        lpfd_pkg::result_t want;
        if (due_results.size() == 0)
        begin
            $display("%0t ns: unexpected result beat, expected none, got %0h/%0b/%0b",
                     $time, m_tdata, m_tuser, m_tlast);
            fault_count++;
        end
        else
        begin
            want = due_results.pop_front();
            report("kind",        64'(want.kind),        64'(m_tuser));
            report("sender_id",   64'(want.sender_id),   64'(m_tdata[7:0]));
            report("receiver_id", 64'(want.receiver_id), 64'(m_tdata[15:8]));
            report("message_id",  64'(unsigned'(want.message_id)), 64'(m_tdata[47:16]));
            report("body_length", want.body_length,      m_tdata[111:48]);
            report("body_byte",   64'(want.body_byte),   64'(m_tdata[119:112]));
            report("last",        64'(want.last),        64'(m_tlast));
        end
    endtask

    // Driver: offers queued bytes, predicts on each accepted beat.
    // Every third stretch of 40 beats runs with no gaps.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            gap_left <= 0;
        end
        else if (!s_tvalid || s_tready)
        begin
            if (s_tvalid)
            begin
                deframe_byte(s_tdata);
                fed_count++;
            end
            if (gap_left != 0)
            begin
                gap_left <= gap_left - 1;
                s_tvalid <= 1'b0;
            end
            else if (stream_bytes.size() != 0)
            begin
                s_tvalid <= 1'b1;
                s_tdata  <= stream_bytes.pop_front();
                gap_left <= draw_wait(((fed_count / 40) % 3) == 0);
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    // Monitor: checks each result beat, then stalls m_tready for a drawn time.
    // Calm stretches here are offset from the driver's.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready   <= 1'b0;
            stall_left <= 0;
        end
        else if (m_tvalid && m_tready)
        begin
            check_result();
            results_seen++;
            stall_draw = draw_wait(((results_seen / 40) % 3) == 1);
            if (stall_draw == 0)
                m_tready <= 1'b1;
            else
            begin
                m_tready   <= 1'b0;
                stall_left <= stall_draw - 1;
            end
        end
        else if (!m_tready)
        begin
            if (stall_left == 0)
                m_tready <= 1'b1;
            else
                stall_left <= stall_left - 1;
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count == CycleLimit)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    task automatic wait_drained();
        while (stream_bytes.size() != 0 || s_tvalid)
            @(negedge clk);
        while (due_results.size() != 0)
            @(negedge clk);
    endtask

    initial
    begin
        int planned;
        int pick;
        int n_body;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed: empty body with extreme ids, one-byte body, body bytes at
        // both extremes
        queue_message(8'h00, 8'hFF, 32'h8000_0000, 64'd0, 0);
        queue_message(8'hFF, 8'h00, 32'h7FFF_FFFF, 64'd1, 0);
        add_stream_byte(8'hFF);
        queue_message(8'hA5, 8'h5A, 32'h0000_0000, 64'd2, 0);
        add_stream_byte(8'h00);
        add_stream_byte(8'hFF);

        // Sender holds off until every result has come out
        wait_drained();

        // Random messages, mostly short bodies with some empty ones
        planned = 0;
        while (planned < RandomBytes)
        begin
            pick = $urandom_range(0, 7);
            if (pick == 0)
                n_body = 0;
            else if (pick == 1)
                n_body = 1;
            else
                n_body = $urandom_range(2, 30);
            queue_message(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                          32'($urandom()), 64'(n_body), n_body);
            planned += 14 + n_body;
            if ($urandom_range(0, 9) == 0)
            begin
                wait_drained();
            end
        end

        // Largest body length and an id of minus one: only the start of the
        // body is sent, the full countdown cannot complete in a run
        queue_message(8'hFF, 8'hFF, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 24);

        wait_drained();
        repeat (DrainCycles) @(posedge clk);

        if (fault_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

// ----- length_prefixed_frame_deframer_top.f -----
design/lpfd_pkg.sv
design/lpfd_in_stage.sv
design/lpfd_parser.sv
design/lpfd_out_stage.sv
design/length_prefixed_frame_deframer_top.sv
bench/length_prefixed_frame_deframer_top_tb.sv
